// ===== rtl/sfrs_pkg.sv =====
package sfrs_pkg;

    // Field widths fixed by the stream format
    localparam int FLOOR_W  = 5;
    localparam int STATUS_W = 2;
    // Compare width: holds any floor field and any floor count up to 64
    localparam int CMP_W    = 7;

    localparam int SFRS_NUM_FLOORS = 32;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_STOP  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

    // Input action codes
    localparam logic ACT_CALL  = 1'b0;
    localparam logic ACT_SWEEP = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic load_call;
        logic load_empty;
        logic start_scan;
        logic emit;
        logic step;
    } sfrs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pending_none;
        logic hit;
        logic last_hit;
        logic out_free;
    } sfrs_stat_t;

endpackage

// ===== rtl/sfrs_ctrl.sv =====
module sfrs_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_action,
    output logic               in_ready,
    input  sfrs_pkg::sfrs_stat_t stat,
    output sfrs_pkg::sfrs_cmd_t  cmd
);
    import sfrs_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    if (in_action == ACT_CALL)
                    begin
                        cmd.load_call = 1'b1;
                    end
                    else if (stat.pending_none)
                    begin
                        cmd.load_empty = 1'b1;
                    end
                    else
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // one floor per cycle; wait on a pending floor until the output frees up
                if (stat.hit)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit = 1'b1;
                        cmd.step = 1'b1;
                        if (stat.last_hit)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/sfrs_datapath.sv =====
module sfrs_datapath
#(
    parameter int NUM_FLOORS = sfrs_pkg::SFRS_NUM_FLOORS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  sfrs_pkg::sfrs_cmd_t            cmd,
    output sfrs_pkg::sfrs_stat_t           stat,
    input  logic [sfrs_pkg::FLOOR_W-1:0]   call_floor,
    input  logic [sfrs_pkg::FLOOR_W-1:0]   head_floor,
    output logic [sfrs_pkg::FLOOR_W-1:0]   stop_floor,
    output logic [sfrs_pkg::STATUS_W-1:0]  status,
    output logic                           last,
    output logic                           out_valid,
    input  logic                           out_ready
);
    import sfrs_pkg::*;

    localparam int               FW      = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
    localparam logic [CMP_W-1:0] NF      = CMP_W'(NUM_FLOORS);
    localparam logic [FW-1:0]    TOP_IDX = FW'(NUM_FLOORS - 1);

    logic [NUM_FLOORS-1:0] pending_reg;
    logic [NUM_FLOORS-1:0] pending_next;
    logic                  sweep_up_reg;
    logic                  sweep_up_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [FW-1:0]         ptr_reg;
    logic [FW-1:0]         ptr_next;
    logic                  dir_up_reg;
    logic                  dir_up_next;
    logic [CMP_W-1:0]      head_reg;
    logic [CMP_W-1:0]      head_next;
    logic [FLOOR_W-1:0]    stop_reg;
    logic [FLOOR_W-1:0]    stop_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic                  last_reg;
    logic                  last_next;

    logic [CMP_W-1:0]      call_ext;
    logic [CMP_W-1:0]      head_ext;
    logic [CMP_W-1:0]      head_m1;
    logic [CMP_W-1:0]      head_reg_m1;
    logic [FW-1:0]         call_idx;
    logic                  call_ok;
    logic                  call_dup;
    logic [NUM_FLOORS-1:0] ptr_mask;
    logic [NUM_FLOORS-1:0] rest;
    logic                  hit;
    logic                  out_free;

    // Call decode and scan pointer lookup
    always_comb
    begin
        call_ext    = CMP_W'(call_floor);
        head_ext    = CMP_W'(head_floor);
        head_m1     = head_ext - CMP_W'(1);
        head_reg_m1 = head_reg - CMP_W'(1);
        call_idx    = call_ext[FW-1:0];
        call_ok     = call_ext < NF;
        call_dup    = !call_ok || pending_reg[call_idx];
        ptr_mask    = NUM_FLOORS'(1) << ptr_reg;
        rest        = pending_reg & ~ptr_mask;
        hit         = pending_reg[ptr_reg];
        out_free    = !out_valid_reg || out_ready;
    end

    assign stat.pending_none = (pending_reg == '0);
    assign stat.hit          = hit;
    assign stat.last_hit     = (rest == '0);
    assign stat.out_free     = out_free;

    // Next-state datapath
    always_comb
    begin
        pending_next   = pending_reg;
        sweep_up_next  = sweep_up_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ptr_next       = ptr_reg;
        dir_up_next    = dir_up_reg;
        head_next      = head_reg;
        stop_next      = stop_reg;
        status_next    = status_reg;
        last_next      = last_reg;

        if (cmd.load_call)
        begin
            out_valid_next = 1'b1;
            stop_next      = call_floor;
            last_next      = 1'b1;
            if (call_dup)
            begin
                status_next = STAT_DUP;
            end
            else
            begin
                status_next  = STAT_ADDED;
                pending_next = pending_reg | (NUM_FLOORS'(1) << call_idx);
            end
        end

        if (cmd.load_empty)
        begin
            out_valid_next = 1'b1;
            stop_next      = '0;
            status_next    = STAT_EMPTY;
            last_next      = 1'b1;
        end

        // Pick the first floor and direction of the sweep
        if (cmd.start_scan)
        begin
            head_next = head_ext;
            if (sweep_up_reg)
            begin
                if (head_ext < NF)
                begin
                    ptr_next    = head_ext[FW-1:0];
                    dir_up_next = 1'b1;
                end
                else
                begin
                    ptr_next    = TOP_IDX;
                    dir_up_next = 1'b0;
                end
            end
            else
            begin
                if (head_ext == '0)
                begin
                    ptr_next    = '0;
                    dir_up_next = 1'b1;
                end
                else if (head_ext < NF)
                begin
                    ptr_next    = head_m1[FW-1:0];
                    dir_up_next = 1'b0;
                end
                else
                begin
                    ptr_next    = TOP_IDX;
                    dir_up_next = 1'b0;
                end
            end
        end

        // Route stop: retire the floor, last when the set runs dry
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            stop_next      = FLOOR_W'(ptr_reg);
            status_next    = STAT_STOP;
            last_next      = (rest == '0);
            pending_next   = rest;
            if (rest == '0)
            begin
                sweep_up_next = !sweep_up_reg;
            end
        end

        // Advance the pointer; at the end of a leg turn back from the head
        if (cmd.step)
        begin
            if (dir_up_reg)
            begin
                if (ptr_reg == TOP_IDX)
                begin
                    ptr_next    = head_reg_m1[FW-1:0];
                    dir_up_next = 1'b0;
                end
                else
                begin
                    ptr_next = ptr_reg + FW'(1);
                end
            end
            else
            begin
                if (ptr_reg == '0)
                begin
                    ptr_next    = head_reg[FW-1:0];
                    dir_up_next = 1'b1;
                end
                else
                begin
                    ptr_next = ptr_reg - FW'(1);
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            sweep_up_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            sweep_up_reg  <= sweep_up_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        dir_up_reg <= dir_up_next;
        head_reg   <= head_next;
        stop_reg   <= stop_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign stop_floor = stop_reg;
    assign status     = status_reg;
    assign last       = last_reg;
    assign out_valid  = out_valid_reg;

endmodule

// ===== rtl/scan_floor_request_scheduler.sv =====
// Channel   Dir  Fields
// s_axis    in   tuser: action; tdata: call_floor, head_floor
// m_axis    out  tdata: stop_floor; tuser: status; tlast: last
//
// A call word's result is registered straight into the output register.
// A sweep walks one floor per cycle with a single pointer over the pending
// bit vector, from the head outward and back, and it ends at the last pending
// floor. A new word is taken only between sweeps.
// Output stalls hold the scan on a pending floor until the result is taken.
// Reset (rst_n low): no calls pending, first sweep goes up, output empty.
module scan_floor_request_scheduler
#(
    parameter int NUM_FLOORS = sfrs_pkg::SFRS_NUM_FLOORS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // call_floor, head_floor
    input  logic                          s_axis_tuser,  // action
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,  // stop_floor
    output logic [sfrs_pkg::STATUS_W-1:0] m_axis_tuser,  // status
    output logic                          m_axis_tlast
);
    import sfrs_pkg::*;

    sfrs_cmd_t          cmd;
    sfrs_stat_t         stat;
    logic [FLOOR_W-1:0] stop_floor;

    sfrs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_action (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sfrs_datapath #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .call_floor (s_axis_tdata[4:0]),
        .head_floor (s_axis_tdata[9:5]),
        .stop_floor (stop_floor),
        .status     (m_axis_tuser),
        .last       (m_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {3'b000, stop_floor};

`ifndef SYNTHESIS
    // a stop is only written into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("route stop written over a waiting word");

    // no new word is taken while a sweep is running
    a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_scan |=> !s_axis_tready)
        else $error("input taken during a sweep");

    // the final stop of a sweep leaves the set empty
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && stat.last_hit) |=> stat.pending_none)
        else $error("calls left pending after the final stop");

    // a call and a sweep start never coincide
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load_call && (cmd.start_scan || cmd.load_empty)))
        else $error("call and sweep decoded together");
`endif

endmodule
